// ----- src/dedc_pkg.sv -----
// Shared types, register indexes and the saturating counter add for the event debounce block.
// Every other file in this block depends on this package.
package dedc_pkg;

	localparam int CNT_W  = 16;
	localparam int THR_W  = 16;
	localparam int STEP_W = 15;
	localparam int DATA_W = 16;
	localparam int IDX_W  = 3;

	typedef logic signed [CNT_W-1:0] count_t;
	typedef logic signed [CNT_W:0]   delta_t;

	typedef enum logic [2:0] {
		ST_INIT      = 3'd0,
		ST_PASSED    = 3'd1,
		ST_FAILED    = 3'd2,
		ST_PREPASSED = 3'd3,
		ST_PREFAILED = 3'd4
	} status_t;

	typedef enum logic [IDX_W-1:0] {
		REG_FAIL_THR  = 3'd0,
		REG_PASS_THR  = 3'd1,
		REG_STEP_UP   = 3'd2,
		REG_STEP_DOWN = 3'd3,
		REG_HEAL      = 3'd4,
		REG_PRESTORE  = 3'd5,
		REG_JUMP_DOWN = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [THR_W-1:0] fail_thr;
		logic signed [THR_W-1:0] pass_thr;
		logic [STEP_W-1:0]       step_up;
		logic [STEP_W-1:0]       step_down;
		logic                    heal_en;
		logic                    prestore_en;
		logic                    jump_down_en;
	} cfg_t;

	typedef struct packed {
		logic fault;
		logic startup;
		logic rst_req;
		logic enable;
		logic dbnc;
	} sample_t;

	typedef struct packed {
		status_t status;
		count_t  count;
		logic    dbnc_last;
		logic    bypass;
		logic    prestore;
	} state_t;

	localparam count_t CNT_MAX = count_t'({1'b0, {(CNT_W-1){1'b1}}});
	localparam count_t CNT_MIN = count_t'({1'b1, {(CNT_W-1){1'b0}}});

	// Adds a signed step to the counter and clamps the result to the counter range.
	function automatic count_t sat_add(input count_t base, input delta_t delta);
		logic signed [CNT_W+1:0] sum;
		sum = {{2{base[CNT_W-1]}}, base} + {delta[CNT_W], delta};
		if (sum > CNT_MAX) begin
			return CNT_MAX;
		end else if (sum < CNT_MIN) begin
			return CNT_MIN;
		end
		return sum[CNT_W-1:0];
	endfunction

endpackage

// ----- src/dedc_cfg.sv -----
// Configuration register file of the event debounce block, loaded with its reset values.
// Depends on dedc_pkg for the register indexes and the cfg_t bundle.
module dedc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dedc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [dedc_pkg::DATA_W-1:0]   cfg_data,
	output dedc_pkg::cfg_t                cfg
);
	import dedc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fail_thr     <= 16'sd100;
			cfg_q.pass_thr     <= -16'sd100;
			cfg_q.step_up      <= 15'd1;
			cfg_q.step_down    <= 15'd1;
			cfg_q.heal_en      <= 1'b1;
			cfg_q.prestore_en  <= 1'b0;
			cfg_q.jump_down_en <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FAIL_THR:  cfg_q.fail_thr     <= cfg_data[THR_W-1:0];
				REG_PASS_THR:  cfg_q.pass_thr     <= cfg_data[THR_W-1:0];
				REG_STEP_UP:   cfg_q.step_up      <= cfg_data[STEP_W-1:0];
				REG_STEP_DOWN: cfg_q.step_down    <= cfg_data[STEP_W-1:0];
				REG_HEAL:      cfg_q.heal_en      <= cfg_data[0];
				REG_PRESTORE:  cfg_q.prestore_en  <= cfg_data[0];
				REG_JUMP_DOWN: cfg_q.jump_down_en <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- src/dedc_update.sv -----
// Next-state logic of the event debounce block: one saturating add plus compares and selection.
// Depends on dedc_pkg for the state, sample and configuration types.
module dedc_update (
	input  dedc_pkg::cfg_t    cfg,
	input  dedc_pkg::sample_t smp,
	input  dedc_pkg::state_t  cur,
	output dedc_pkg::state_t  nxt
);
	import dedc_pkg::*;

	status_t st;
	count_t  cnt;
	count_t  base;
	count_t  sum;
	delta_t  delta;
	logic    abort;

	assign abort = smp.rst_req || !smp.enable;
	assign st    = cur.dbnc_last ? cur.status : ST_INIT;
	assign cnt   = cur.dbnc_last ? cur.count : '0;
	assign delta = smp.fault ?
		delta_t'({{(CNT_W+1-STEP_W){1'b0}}, cfg.step_up}) :
		-delta_t'({{(CNT_W+1-STEP_W){1'b0}}, cfg.step_down});

	always_comb begin
		base = cnt;
		if (st == ST_FAILED && !smp.fault && cfg.jump_down_en && cnt > 0) begin
			base = '0;
		end else if ((st == ST_FAILED || st == ST_PASSED) && smp.fault && cnt < 0) begin
			base = '0;
		end
	end

	assign sum = sat_add(base, delta);

	always_comb begin
		nxt           = cur;
		nxt.dbnc_last = smp.dbnc;
		if (!smp.dbnc) begin
			nxt.bypass = 1'b1;
			if (!cur.bypass || cur.dbnc_last || !smp.startup || abort) begin
				nxt.status = ST_INIT;
			end else begin
				nxt.status = smp.fault ? ST_PREFAILED : ST_PREPASSED;
			end
		end else begin
			nxt.status = st;
			nxt.count  = cnt;
			unique case (st)
				ST_INIT: begin
					if (cfg.prestore_en) begin
						nxt.prestore = 1'b0;
					end
					if (!smp.startup || abort) begin
						nxt.count = '0;
					end else if (!smp.fault) begin
						if (sum <= cfg.pass_thr) begin
							nxt.status = ST_PASSED;
							nxt.count  = cfg.pass_thr;
						end else begin
							nxt.count = sum;
						end
					end else begin
						if (sum >= cfg.fail_thr) begin
							nxt.status = ST_FAILED;
							nxt.count  = cfg.fail_thr;
						end else begin
							nxt.count = sum;
						end
					end
				end
				ST_FAILED: begin
					if (cfg.prestore_en) begin
						nxt.prestore = 1'b0;
					end
					if (abort) begin
						nxt.status = ST_INIT;
						nxt.count  = '0;
					end else if (!smp.fault) begin
						if (cfg.heal_en) begin
							if (sum <= cfg.pass_thr) begin
								nxt.status = ST_PASSED;
								nxt.count  = cfg.pass_thr;
							end else begin
								nxt.count = sum;
							end
						end
					end else begin
						if (base <= cfg.fail_thr) begin
							nxt.count = (sum > cfg.fail_thr) ? cfg.fail_thr : sum;
						end else begin
							nxt.count = base;
						end
					end
				end
				ST_PASSED: begin
					if (cfg.prestore_en) begin
						nxt.prestore = 1'b0;
					end
					if (abort) begin
						nxt.status = ST_INIT;
						nxt.count  = '0;
					end else if (!smp.fault) begin
						if (cnt >= cfg.pass_thr) begin
							nxt.count = (sum < cfg.pass_thr) ? cfg.pass_thr : sum;
						end
					end else begin
						if (cfg.prestore_en && cnt == cfg.pass_thr) begin
							nxt.prestore = 1'b1;
						end
						if (sum >= cfg.fail_thr) begin
							nxt.status = ST_FAILED;
							nxt.count  = cfg.fail_thr;
						end else begin
							nxt.count = sum;
						end
					end
				end
				ST_PREPASSED, ST_PREFAILED: begin
					nxt.status = ST_FAILED;
				end
				default: begin
					nxt.status = ST_FAILED;
				end
			endcase
		end
	end

endmodule

// ----- src/diag_event_debounce_counter.sv -----
// Counter-based diagnostic event debouncer: sample input register, state and result register.
// Depends on dedc_pkg, dedc_cfg and dedc_update.
//
// Each input beat is one periodic diagnostic sample carrying the fault flag and the
// startup, reset request, monitor enable and debounce enable flags. Each sample yields
// exactly one result beat with the event status, the signed fault counter, the
// prestore trigger and the bypass flag as they stand after that sample.
// The input channel and the result channel use valid and ready. The configuration
// channel writes one register per beat and is always ready; it is meant to be used
// only while no sample is in flight.
// A sample accepted at a clock edge is held in the sample register, the state update is
// computed combinationally from that register, and the result register takes that update
// and drives the result beat. Throughput is one sample per clock while the receiver does
// not stall: the sample register and the result register move together, so a new sample
// is taken while the previous result is delivered.
// When the receiver stalls, the result register holds its beat, the sample register
// holds the next sample, and the input stops being ready until the stall ends.
// Reset clears the event state to init with a zero counter and loads the configuration
// registers with their default values; the sample and result registers are not reset.
module diag_event_debounce_counter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dedc_pkg::IDX_W-1:0]         cfg_index,
	input  logic [dedc_pkg::DATA_W-1:0]        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               fault_present,
	input  logic                               startup_done,
	input  logic                               reset_request,
	input  logic                               monitor_enable,
	input  logic                               debounce_on,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         event_status,
	output logic signed [dedc_pkg::CNT_W-1:0]  fault_count,
	output logic                               prestore_trigger,
	output logic                               bypass_armed
);
	import dedc_pkg::*;

	cfg_t    cfg;
	sample_t smp_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	state_t  res_q;
	logic    out_valid_q;
	logic    adv;

	dedc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dedc_update u_update (
		.cfg (cfg),
		.smp (smp_s1),
		.cur (state_q),
		.nxt (state_nxt)
	);

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			smp_s1.fault   <= fault_present;
			smp_s1.startup <= startup_done;
			smp_s1.rst_req <= reset_request;
			smp_s1.enable  <= monitor_enable;
			smp_s1.dbnc    <= debounce_on;
		end
		if (adv) begin
			res_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			out_valid_q       <= 1'b0;
			state_q.status    <= ST_INIT;
			state_q.count     <= '0;
			state_q.dbnc_last <= 1'b0;
			state_q.bypass    <= 1'b0;
			state_q.prestore  <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign event_status     = res_q.status;
	assign fault_count      = res_q.count;
	assign prestore_trigger = res_q.prestore;
	assign bypass_armed     = res_q.bypass;

	// A sample that moves on always shows up as a result beat.
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("sample advanced without producing a result beat");

	// After a debounced sample the status is never one of the pre-statuses.
	a_dbnc_status: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.dbnc_last |-> (state_q.status == ST_INIT || state_q.status == ST_PASSED ||
			state_q.status == ST_FAILED))
		else $error("pre-status held after a debounced sample");

	// The bypass flag is only cleared by reset.
	a_bypass_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bypass |=> state_q.bypass)
		else $error("bypass flag cleared without reset");

	// A stalled sample keeps its register contents until it moves on.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(smp_s1)))
		else $error("stalled sample register changed");

	// The state only changes when a sample advances.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("event state changed without a sample");

endmodule
